@@ rtl/core/bdq_pkg.sv @@
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared widths, request and status codes for the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

	localparam int CAPACITY_DFLT = 64;

	localparam int REQ_W    = 2;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 7;
	localparam int LIMIT_W  = 7;

	localparam logic [LIMIT_W-1:0] LIMIT_RST = 7'd64;

	// request codes
	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 2'd2;
	localparam logic [REQ_W-1:0] REQ_POP_BACK   = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] STS_PUSHED    = 2'd0;
	localparam logic [STATUS_W-1:0] STS_POPPED    = 2'd1;
	localparam logic [STATUS_W-1:0] STS_EVICTED   = 2'd2;
	localparam logic [STATUS_W-1:0] STS_POP_EMPTY = 2'd3;

endpackage

@@ rtl/core/bdq_ifs.sv @@
// ----------------------------------------------------------------------------
// bdq_req_if / bdq_rsp_if
// Valid/ready channels carrying deque requests and their results.
// ----------------------------------------------------------------------------
interface bdq_req_if
	import bdq_pkg::*;
;
	logic                      valid;
	logic                      ready;
	logic [REQ_W-1:0]          req_type;
	logic signed [VALUE_W-1:0] push_value;

	modport source (output valid, output req_type, output push_value, input ready);
	modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface bdq_rsp_if
	import bdq_pkg::*;
;
	logic                      valid;
	logic                      ready;
	logic [STATUS_W-1:0]       status;
	logic signed [VALUE_W-1:0] removed_value;
	logic [OCC_W-1:0]          occupancy;

	modport source (output valid, output status, output removed_value, output occupancy,
		input ready);
	modport sink   (input valid, input status, input removed_value, input occupancy,
		output ready);
endinterface

@@ rtl/core/bounded_deque_with_eviction_top.sv @@
// ----------------------------------------------------------------------------
// bounded_deque_with_eviction_top
// Ring-buffer double-ended queue of signed 32-bit words with eviction.
// ----------------------------------------------------------------------------
// Takes one request word per clock and returns one result word in the cycle
// after acceptance; throughput is one request per cycle while the result
// side keeps taking words, since a request is accepted in the same cycle in
// which the pending result leaves. The item memory has a registered read
// port: the removed word of a pop or an eviction is read at acceptance and
// appears with the result. Head, tail and count live in flip-flops and
// advance at acceptance, so the next request already sees the updated
// ring. The occupancy limit is clamped to 1..CAPACITY; a push that finds
// the count at or above it drops one word from the opposite end. Write
// the limit only while the block is idle.
// ----------------------------------------------------------------------------
module bounded_deque_with_eviction_top
	import bdq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DFLT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [LIMIT_W-1:0] cfg_wr_data,
	bdq_req_if.sink            req,
	bdq_rsp_if.source          rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	// common width for count/limit compares, one bit of headroom
	localparam int LW = ((CW > LIMIT_W) ? CW : LIMIT_W) + 1;

	localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);

	// ring state
	logic [AW-1:0]      head_q, tail_q;
	logic [CW-1:0]      count_q;
	logic [LIMIT_W-1:0] limit_q;

	// item memory
	logic [VALUE_W-1:0] mem [CAPACITY];
	logic [VALUE_W-1:0] rd_s1;

	// result stage
	logic                rsp_vld_q;
	logic [STATUS_W-1:0] status_s1;
	logic                rm_vld_s1;
	logic [OCC_W-1:0]    occ_s1;

	// next-state logic
	logic                accept;
	logic                is_push, is_front, empty, evict, take, take_front, clear;
	logic [AW-1:0]       head_prev, head_next, tail_prev, tail_next;
	logic [AW-1:0]       head_n, tail_n, wr_addr, rd_addr;
	logic [CW-1:0]       count_n;
	logic [LW-1:0]       lim_eff;
	logic [STATUS_W-1:0] status_n;

	// accept whenever the result register is free or drains this cycle
	assign req.ready = !rsp_vld_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign head_prev = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
	assign head_next = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign tail_prev = (tail_q == '0) ? LAST_IDX : tail_q - 1'b1;
	assign tail_next = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;

	// clamp the limit to 1..CAPACITY
	always_comb begin
		if (limit_q == '0) begin
			lim_eff = LW'(1);
		end else if (LW'(limit_q) > LW'(CAPACITY)) begin
			lim_eff = LW'(CAPACITY);
		end else begin
			lim_eff = LW'(limit_q);
		end
	end

	assign is_push  = (req.req_type == REQ_PUSH_FRONT) || (req.req_type == REQ_PUSH_BACK);
	assign is_front = (req.req_type == REQ_PUSH_FRONT) || (req.req_type == REQ_POP_FRONT);
	assign empty    = (count_q == '0);
	assign evict    = is_push && (LW'(count_q) >= lim_eff);
	// a word leaves the ring: eviction, or a pop on a non-empty queue
	assign take     = evict || (!is_push && !empty);
	// an eviction on a front push drops the back word, and the reverse
	assign take_front = is_push ? !is_front : is_front;
	assign rd_addr    = take_front ? head_q : tail_prev;
	assign wr_addr    = is_front ? head_prev : tail_q;
	// popping the last word leaves the ring cleanly at slot zero
	assign clear      = !is_push && (count_q == CW'(1));

	always_comb begin
		head_n   = head_q;
		tail_n   = tail_q;
		count_n  = count_q;
		status_n = STS_POP_EMPTY;
		if (is_push) begin
			status_n = evict ? STS_EVICTED : STS_PUSHED;
			if (evict) begin
				if (take_front) begin
					head_n = head_next;
				end else begin
					tail_n = tail_prev;
				end
			end else begin
				count_n = count_q + 1'b1;
			end
			if (is_front) begin
				head_n = head_prev;
			end else begin
				tail_n = tail_next;
			end
		end else if (!empty) begin
			status_n = STS_POPPED;
			count_n  = count_q - 1'b1;
			if (clear) begin
				head_n = '0;
				tail_n = '0;
			end else if (take_front) begin
				head_n = head_next;
			end else begin
				tail_n = tail_prev;
			end
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RST;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	// ring pointers and count: advance at acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			head_q  <= head_n;
			tail_q  <= tail_n;
			count_q <= count_n;
		end
	end

	// item memory: one write and one registered read per cycle. When a
	// front push evicts from a full ring both hit the same slot; the read
	// returns the old word, which is the one dropped.
	always_ff @(posedge clk) begin
		if (accept && is_push) begin
			mem[wr_addr] <= req.push_value;
		end
		if (accept && take) begin
			rd_s1 <= mem[rd_addr];
		end
	end

	// result valid: set on acceptance, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (accept) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	// result payload: hold until the next acceptance
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_n;
			rm_vld_s1 <= take;
			occ_s1    <= LW'(count_n) >> 0 == '0 ? '0 : OCC_W'(LW'(count_n));
		end
	end

	assign rsp.valid         = rsp_vld_q;
	assign rsp.status        = status_s1;
	assign rsp.removed_value = rm_vld_s1 ? rd_s1 : '0;
	assign rsp.occupancy     = occ_s1;

	// ---------------------------------------------------------------- checks
	logic [CW:0] ring_sum;
	logic [AW-1:0] tail_exp;

	assign ring_sum = (CW + 1)'(head_q) + (CW + 1)'(count_q);
	assign tail_exp = (ring_sum >= (CW + 1)'(CAPACITY)) ?
		AW'(ring_sum - (CW + 1)'(CAPACITY)) : AW'(ring_sum);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("item count above capacity");

	a_ring_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q == tail_exp)
		else $error("tail does not sit count slots past head");

	a_empty_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == '0 && tail_q == '0))
		else $error("empty ring not parked at slot zero");

	a_evict_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && evict) |=> $stable(count_q))
		else $error("eviction changed the count");

	a_pop_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_push && empty) |=>
		(rsp.status == STS_POP_EMPTY && rsp.occupancy == '0 && rsp.removed_value == '0))
		else $error("pop on empty gave a wrong result");

endmodule

@@ tb/sv/bounded_deque_with_eviction_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_deque_with_eviction_top_tb
// Self-checking bench for the bounded deque with eviction.
// ----------------------------------------------------------------------------
// A short table of requests covers empty pops, the value extremes, clean
// emptying and a limit written as zero. Random phases follow, each under its
// own occupancy limit and push ratio. Every accepted request runs through a
// ring-buffer predictor kept here, and every result word is compared field
// by field with the oldest prediction. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module bounded_deque_with_eviction_top_tb;
	import bdq_pkg::*;

	localparam int DEPTH           = CAPACITY_DFLT;
	localparam int ITEMS_PER_PHASE = 160;
	localparam int N_PHASES        = 12;
	localparam int N_DIRECTED      = 24;
	localparam int ANY_LIMIT       = -1;

	// row kinds of the directed table
	localparam logic ROW_REQ       = 1'b0;
	localparam logic ROW_SET_LIMIT = 1'b1;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [VALUE_W-1:0]  removed;
		logic [OCC_W-1:0]    occ;
	} deque_outcome_t;

	// For ROW_SET_LIMIT rows the word column carries the limit to write.
	typedef struct packed {
		logic                row_op;
		logic [REQ_W-1:0]    kind;
		logic [VALUE_W-1:0]  word;
		logic                chk;
		logic [STATUS_W-1:0] status;
		logic [VALUE_W-1:0]  removed;
		logic [OCC_W-1:0]    occ;
	} stim_row_t;

	// Results are typed in only where they follow at a glance; the rest come
	// from the predictor.
	localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		//  op             kind            word          chk   status         removed       occ
		'{ROW_REQ,       REQ_POP_FRONT,  32'h00000000, 1'b1, STS_POP_EMPTY, 32'h00000000, 7'd0},
		'{ROW_REQ,       REQ_POP_BACK,   32'h00000000, 1'b1, STS_POP_EMPTY, 32'h00000000, 7'd0},
		'{ROW_REQ,       REQ_PUSH_FRONT, 32'h7FFFFFFF, 1'b1, STS_PUSHED,    32'h00000000, 7'd1},
		'{ROW_REQ,       REQ_PUSH_BACK,  32'h80000000, 1'b1, STS_PUSHED,    32'h00000000, 7'd2},
		'{ROW_REQ,       REQ_PUSH_FRONT, 32'hFFFFFFFF, 1'b1, STS_PUSHED,    32'h00000000, 7'd3},
		'{ROW_REQ,       REQ_PUSH_BACK,  32'h00000000, 1'b1, STS_PUSHED,    32'h00000000, 7'd4},
		'{ROW_REQ,       REQ_POP_FRONT,  32'h00000000, 1'b1, STS_POPPED,    32'hFFFFFFFF, 7'd3},
		'{ROW_REQ,       REQ_POP_BACK,   32'h00000000, 1'b1, STS_POPPED,    32'h00000000, 7'd2},
		'{ROW_REQ,       REQ_POP_BACK,   32'h00000000, 1'b1, STS_POPPED,    32'h80000000, 7'd1},
		'{ROW_REQ,       REQ_POP_FRONT,  32'h00000000, 1'b1, STS_POPPED,    32'h7FFFFFFF, 7'd0},
		'{ROW_REQ,       REQ_POP_BACK,   32'h00000000, 1'b1, STS_POP_EMPTY, 32'h00000000, 7'd0},
		'{ROW_REQ,       REQ_PUSH_BACK,  32'h55555555, 1'b1, STS_PUSHED,    32'h00000000, 7'd1},
		'{ROW_REQ,       REQ_PUSH_FRONT, 32'hAAAAAAAA, 1'b1, STS_PUSHED,    32'h00000000, 7'd2},
		'{ROW_SET_LIMIT, REQ_PUSH_FRONT, 32'h00000000, 1'b0, STS_PUSHED,    32'h00000000, 7'd0},
		'{ROW_REQ,       REQ_PUSH_FRONT, 32'h12345678, 1'b0, STS_PUSHED,    32'h00000000, 7'd0},
		'{ROW_REQ,       REQ_PUSH_BACK,  32'h9ABCDEF0, 1'b0, STS_PUSHED,    32'h00000000, 7'd0},
		'{ROW_REQ,       REQ_POP_FRONT,  32'h00000000, 1'b0, STS_PUSHED,    32'h00000000, 7'd0},
		'{ROW_SET_LIMIT, REQ_PUSH_FRONT, 32'h00000001, 1'b0, STS_PUSHED,    32'h00000000, 7'd0},
		'{ROW_REQ,       REQ_POP_BACK,   32'h00000000, 1'b0, STS_PUSHED,    32'h00000000, 7'd0},
		'{ROW_REQ,       REQ_PUSH_BACK,  32'hDEADBEEF, 1'b0, STS_PUSHED,    32'h00000000, 7'd0},
		'{ROW_REQ,       REQ_PUSH_FRONT, 32'h00000000, 1'b0, STS_PUSHED,    32'h00000000, 7'd0},
		'{ROW_SET_LIMIT, REQ_PUSH_FRONT, 32'h0000007F, 1'b0, STS_PUSHED,    32'h00000000, 7'd0},
		'{ROW_REQ,       REQ_POP_FRONT,  32'h00000000, 1'b0, STS_PUSHED,    32'h00000000, 7'd0},
		'{ROW_REQ,       REQ_POP_BACK,   32'h00000000, 1'b0, STS_PUSHED,    32'h00000000, 7'd0}
	};

	// Phase plan: a full ring first, then a limit well below the count so that
	// pushes evict without shrinking it, then a mix with the clamped extremes.
	localparam int PHASE_LIMITS   [N_PHASES] = '{127, 5, 64, 0, 2, 1, 65, 3, 100, ANY_LIMIT,
		64, ANY_LIMIT};
	localparam int PHASE_PUSH_PCT [N_PHASES] = '{85, 70, 50, 60, 30, 55, 90, 40, 25, 50, 80, 45};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wr_en = 1'b0;
	logic [LIMIT_W-1:0] cfg_wr_data = LIMIT_RST;

	bdq_req_if req_ch ();
	bdq_rsp_if rsp_ch ();

	bounded_deque_with_eviction_top #(
		.CAPACITY(DEPTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req        (req_ch),
		.rsp        (rsp_ch)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Predictor state: a ring of words with front slot, slot after the back,
	// and the count. Reset values match the block's.
	// ------------------------------------------------------------------------
	logic [VALUE_W-1:0] ring_words [DEPTH];
	int unsigned        front_slot = 0;
	int unsigned        after_back = 0;
	int unsigned        held_words = 0;
	logic [LIMIT_W-1:0] limit_now = LIMIT_RST;

	deque_outcome_t     due_results [$];

	// typed expectation that goes with the word now on the request channel
	logic               row_chk = 1'b0;
	deque_outcome_t     row_outcome = '0;

	int mismatches   = 0;
	int reqs_taken   = 0;
	int words_seen   = 0;
	int evictions    = 0;
	int empty_pops   = 0;
	int limit_writes = 0;
	int peak_occ     = 0;

	function automatic logic [VALUE_W-1:0] drop_front_word();
		logic [VALUE_W-1:0] w;
		w = ring_words[front_slot];
		front_slot = (front_slot + 1 == DEPTH) ? 0 : front_slot + 1;
		held_words--;
		return w;
	endfunction

	function automatic logic [VALUE_W-1:0] drop_back_word();
		after_back = (after_back == 0) ? DEPTH - 1 : after_back - 1;
		held_words--;
		return ring_words[after_back];
	endfunction

	// Advance the ring by one request and give the result word it causes.
	function automatic deque_outcome_t deque_after_request(input logic [REQ_W-1:0] kind,
		input logic [VALUE_W-1:0] word);
		deque_outcome_t res;
		int unsigned    cap;
		cap = limit_now;
		if (cap == 0)
			cap = 1;
		if (cap > DEPTH)
			cap = DEPTH;
		res = '0;
		if (kind == REQ_PUSH_FRONT || kind == REQ_PUSH_BACK) begin
			res.status = STS_PUSHED;
			// evict from the end opposite the push
			if (held_words + 1 > cap) begin
				res.status  = STS_EVICTED;
				res.removed = (kind == REQ_PUSH_FRONT) ? drop_back_word() : drop_front_word();
			end
			if (kind == REQ_PUSH_FRONT) begin
				front_slot = (front_slot == 0) ? DEPTH - 1 : front_slot - 1;
				ring_words[front_slot] = word;
			end else begin
				ring_words[after_back] = word;
				after_back = (after_back + 1 == DEPTH) ? 0 : after_back + 1;
			end
			held_words++;
		end else if (held_words == 0) begin
			res.status = STS_POP_EMPTY;
		end else begin
			res.status  = STS_POPPED;
			res.removed = (kind == REQ_POP_FRONT) ? drop_front_word() : drop_back_word();
			// last word gone: restart the ring cleanly
			if (held_words == 0) begin
				front_slot = 0;
				after_back = 0;
			end
		end
		res.occ = held_words[OCC_W-1:0];
		return res;
	endfunction

	task automatic check_field(input string field, input logic signed [63:0] want,
		input logic signed [63:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
		end
	endtask

	// ------------------------------------------------------------------------
	// Monitor: predict on each accepted request first, then match each
	// accepted result word against the oldest prediction.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : watch_channels
		deque_outcome_t fresh;
		deque_outcome_t want;
		if (arst_n) begin
			if (cfg_wr_en)
				limit_now = cfg_wr_data;
			if (req_ch.valid && req_ch.ready) begin
				fresh = deque_after_request(req_ch.req_type, req_ch.push_value);
				reqs_taken++;
				if (fresh.status == STS_EVICTED)
					evictions++;
				if (fresh.status == STS_POP_EMPTY)
					empty_pops++;
				if (fresh.occ > peak_occ)
					peak_occ = fresh.occ;
				// take the typed value where the table gives one
				due_results.insert(due_results.size(), row_chk ? row_outcome : fresh);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				words_seen++;
				if (due_results.size() == 0) begin
					mismatches++;
					$display("%0t ns: result word with nothing expected, status %0d", $time,
						rsp_ch.status);
				end else begin
					want = due_results.pop_front();
					check_field("status", want.status, rsp_ch.status);
					check_field("removed_value", $signed(want.removed), rsp_ch.removed_value);
					check_field("occupancy", want.occ, rsp_ch.occupancy);
				end
			end
		end
	end

	// mostly no gap, often a short one, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 8);
		return $urandom_range(15, 40);
	endfunction

	// Idle for the gap, then hold the word until the block takes it.
	task automatic send_request(input logic [REQ_W-1:0] kind, input logic [VALUE_W-1:0] word,
		input logic chk, input deque_outcome_t typed, input int gap);
		repeat (gap) begin
			@(negedge clk);
			req_ch.valid = 1'b0;
		end
		@(negedge clk);
		req_ch.valid      = 1'b1;
		req_ch.req_type   = kind;
		req_ch.push_value = word;
		row_chk           = chk;
		row_outcome       = typed;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	// Write the limit only once every result is back and the block is quiet.
	task automatic set_limit(input logic [LIMIT_W-1:0] value);
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		@(negedge clk);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = value;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		limit_writes++;
	endtask

	// Result side: runs of ready, broken by stalls; the odd long run keeps the
	// channel free of stalls for a stretch.
	initial begin : result_side
		int run;
		int stall;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			run = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
			@(negedge clk);
			rsp_ch.ready = 1'b1;
			repeat (run - 1) @(negedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				@(negedge clk);
				rsp_ch.ready = 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus: directed table, then random phases, then drain and verdict.
	// ------------------------------------------------------------------------
	initial begin : request_side
		stim_row_t          row;
		int                 lim;
		logic               steady;
		logic [REQ_W-1:0]   kind;
		logic [VALUE_W-1:0] word;
		req_ch.valid      = 1'b0;
		req_ch.req_type   = REQ_PUSH_FRONT;
		req_ch.push_value = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < N_DIRECTED; i++) begin
			row = DIRECTED_ROWS[i];
			if (row.row_op == ROW_SET_LIMIT)
				set_limit(row.word[LIMIT_W-1:0]);
			else
				send_request(row.kind, row.word, row.chk, '{row.status, row.removed, row.occ},
					pick_gap());
		end

		for (int p = 0; p < N_PHASES; p++) begin
			lim = PHASE_LIMITS[p];
			if (lim == ANY_LIMIT)
				lim = $urandom_range(0, 127);
			set_limit(lim[LIMIT_W-1:0]);
			// every third phase keeps the request side busy back to back
			steady = (p % 3 == 1);
			repeat (ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 99) < PHASE_PUSH_PCT[p])
					kind = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
				else
					kind = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
				word = $urandom;
				// drop in a value extreme now and then
				case ($urandom_range(0, 15))
					0: word = 32'h7FFFFFFF;
					1: word = 32'h80000000;
					2: word = 32'h00000000;
					3: word = 32'hFFFFFFFF;
					default: ;
				endcase
				send_request(kind, word, 1'b0, '0, steady ? 0 : pick_gap());
			end
		end

		@(negedge clk);
		req_ch.valid = 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (due_results.size() != 0) begin
			mismatches++;
			$display("%0t ns: %0d result words never arrived", $time, due_results.size());
		end

		$display("Ran %0d requests under %0d limit settings; %0d result words checked.",
			reqs_taken, limit_writes, words_seen);
		$display("Saw %0d evictions, %0d pops on empty, peak occupancy %0d; %0d mismatches.",
			evictions, empty_pops, peak_occ, mismatches);
		if (mismatches == 0)
			$display("[bounded_deque_with_eviction_top] OK");
		else
			$display("[bounded_deque_with_eviction_top] ERROR");
		$finish;
	end

	// hang guard, several times the slowest legal run
	initial begin : hang_guard
		#10_000_000;
		$display("%0t ns: run did not finish in time", $time);
		$display("[bounded_deque_with_eviction_top] ERROR");
		$finish;
	end

endmodule
